[src/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// operation codes and control word shared by the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int KIND_BITS = 3;

    typedef logic [KIND_BITS-1:0] t_kind;

    localparam t_kind KIND_ADD   = 3'd0;
    localparam t_kind KIND_SUB   = 3'd1;
    localparam t_kind KIND_MUL   = 3'd2;
    localparam t_kind KIND_SCALE = 3'd3;
    localparam t_kind KIND_CDIV  = 3'd4;
    localparam t_kind KIND_RDIV  = 3'd5;
    localparam t_kind KIND_MAG   = 3'd6;

    // control that travels with each word down the pipeline
    typedef struct packed {
        t_kind kind;
        logic  div_zero;
        logic  neg_re;
        logic  neg_im;
        logic  ovf_re;
        logic  ovf_im;
    } t_ctrl;

endpackage

[src/cau_ifs.sv]
// ----------------------------------------------------------------------------
// cau interfaces
// valid/ready channels for operand words and result words
// ----------------------------------------------------------------------------
interface cau_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [cau_pkg::KIND_BITS-1:0] kind;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;

    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] r_re;
    logic signed [WORD_BITS-1:0] r_im;
    logic                        div_zero;
    logic                        overflow;

    modport source (output valid, r_re, r_im, div_zero, overflow, input ready);
    modport sink   (input valid, r_re, r_im, div_zero, overflow, output ready);
endinterface

[src/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// pipelined complex add/sub/mul/scale/divide/magnitude on signed fixed point
// ----------------------------------------------------------------------------
// usage
//   i_in carries one operand word per handshake: kind, a_re, a_im, b_re, b_im
//   o_out returns exactly one result word per operand word, in order:
//   r_re, r_im, div_zero, overflow
//   a word is moved at a rising edge with valid and ready both high
// timing
//   one word per cycle while o_out.ready stays high; pipeline depth is
//   set by the divider and square root, which resolve one quotient/root bit
//   per pipeline stage (WORD_BITS stages) behind three set-up stages
// reset
//   synchronous active-low i_rst_n empties the pipeline and the output side
// stall
//   if the receiver holds ready low, one more word lands in a skid register
//   and the whole pipeline then freezes; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module complex_arith_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cau_in_if.sink        i_in,
    cau_out_if.source     o_out
);
    localparam int W   = WORD_BITS;
    localparam int PW  = 2*WORD_BITS;
    localparam int VW  = 2*WORD_BITS+1;
    localparam int SW  = 3*WORD_BITS+FRAC_BITS;
    localparam int NPS = WORD_BITS+4;   // front 3, bit steps, back 1

    typedef struct packed {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                dz;
        logic                ov;
    } t_res;

    // pipeline advances as long as the skid register is free
    logic             en;
    logic [NPS-1:0]   r_vld;
    logic             r_ov, r_sv;
    t_res             r_od, r_sd, pipe_res;
    logic             push, take;

    assign en         = !r_sv;
    assign i_in.ready = en;

    // stage boundaries: index 0 leaves the front, index k+1 leaves bit step k
    cau_pkg::t_ctrl    s_ctrl   [W+1];
    logic signed [VW-1:0] s_val_re [W+1];
    logic signed [VW-1:0] s_val_im [W+1];
    logic [SW-1:0]     s_rem_re [W+1];
    logic [SW-1:0]     s_rem_im [W+1];
    logic [PW-1:0]     s_den    [W+1];
    logic [W-1:0]      s_q_re   [W+1];
    logic [W-1:0]      s_q_im   [W+1];

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_kind   (i_in.kind),
        .i_a_re   (i_in.a_re),
        .i_a_im   (i_in.a_im),
        .i_b_re   (i_in.b_re),
        .i_b_im   (i_in.b_im),
        .o_ctrl   (s_ctrl[0]),
        .o_val_re (s_val_re[0]),
        .o_val_im (s_val_im[0]),
        .o_rem_re (s_rem_re[0]),
        .o_rem_im (s_rem_im[0]),
        .o_den    (s_den[0])
    );

    assign s_q_re[0] = '0;
    assign s_q_im[0] = '0;

    // most significant quotient/root bit first
    for (genvar k = 0; k < W; k++) begin : g_step
        cau_step #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .BIT_IDX   (W-1-k)
        ) u_step (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_ctrl   (s_ctrl[k]),
            .i_val_re (s_val_re[k]),
            .i_val_im (s_val_im[k]),
            .i_rem_re (s_rem_re[k]),
            .i_rem_im (s_rem_im[k]),
            .i_den    (s_den[k]),
            .i_q_re   (s_q_re[k]),
            .i_q_im   (s_q_im[k]),
            .o_ctrl   (s_ctrl[k+1]),
            .o_val_re (s_val_re[k+1]),
            .o_val_im (s_val_im[k+1]),
            .o_rem_re (s_rem_re[k+1]),
            .o_rem_im (s_rem_im[k+1]),
            .o_den    (s_den[k+1]),
            .o_q_re   (s_q_re[k+1]),
            .o_q_im   (s_q_im[k+1])
        );
    end

    cau_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ctrl     (s_ctrl[W]),
        .i_val_re   (s_val_re[W]),
        .i_val_im   (s_val_im[W]),
        .i_q_re     (s_q_re[W]),
        .i_q_im     (s_q_im[W]),
        .o_re       (pipe_res.re),
        .o_im       (pipe_res.im),
        .o_div_zero (pipe_res.dz),
        .o_overflow (pipe_res.ov)
    );

    // valid bits ride alongside the data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NPS-2:0], i_in.valid};
        end
    end

    // output register with one skid entry behind it
    assign push = en && r_vld[NPS-1];
    assign take = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (push) begin
            if (!r_ov || take) begin
                r_od <= pipe_res;
                r_ov <= 1'b1;
            end else begin
                r_sd <= pipe_res;
                r_sv <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.r_re     = r_od.re;
    assign o_out.r_im     = r_od.im;
    assign o_out.div_zero = r_od.dz;
    assign o_out.overflow = r_od.ov;

    // skid entry only ever fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry full with empty output register");

    // a word leaving the pipeline into a stalled output goes to the skid entry
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_ov && !o_out.ready) |=> r_sv)
        else $error("word lost at stalled output");

    // a zero divisor never reports saturation
    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.div_zero && o_out.overflow))
        else $error("div_zero and overflow both set");

    // a zero divisor forces a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_zero) |-> (o_out.r_re == '0 && o_out.r_im == '0))
        else $error("nonzero result with zero divisor");

endmodule

[src/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// products, sums and divider/root set-up over three register stages
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [cau_pkg::KIND_BITS-1:0]        i_kind,
    input  logic signed [WORD_BITS-1:0]          i_a_re,
    input  logic signed [WORD_BITS-1:0]          i_a_im,
    input  logic signed [WORD_BITS-1:0]          i_b_re,
    input  logic signed [WORD_BITS-1:0]          i_b_im,
    output cau_pkg::t_ctrl                       o_ctrl,
    output logic signed [2*WORD_BITS:0]          o_val_re,
    output logic signed [2*WORD_BITS:0]          o_val_im,
    output logic [3*WORD_BITS+FRAC_BITS-1:0]     o_rem_re,
    output logic [3*WORD_BITS+FRAC_BITS-1:0]     o_rem_im,
    output logic [2*WORD_BITS-1:0]               o_den
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2*WORD_BITS;
    localparam int VW = 2*WORD_BITS+1;
    localparam int SW = 3*WORD_BITS+FRAC_BITS;

    // stage a: operands and products
    cau_pkg::t_kind        r_a_kind;
    logic signed [W-1:0]   r_a_re, r_a_im, r_a_bre, r_a_bim;
    logic signed [PW-1:0]  r_a_p_rr, r_a_p_ii, r_a_p_ir, r_a_p_ri, r_a_p_bb, r_a_p_cc;
    logic signed [W-1:0]   n_mbr, n_mbi;

    // magnitude squares the first operand through the same multipliers
    always_comb begin
        n_mbr = (i_kind == cau_pkg::KIND_MAG) ? i_a_re : i_b_re;
        n_mbi = (i_kind == cau_pkg::KIND_MAG) ? i_a_im : i_b_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_kind <= i_kind;
            r_a_re   <= i_a_re;
            r_a_im   <= i_a_im;
            r_a_bre  <= i_b_re;
            r_a_bim  <= i_b_im;
            r_a_p_rr <= PW'(i_a_re) * PW'(n_mbr);
            r_a_p_ii <= PW'(i_a_im) * PW'(n_mbi);
            r_a_p_ir <= PW'(i_a_im) * PW'(i_b_re);
            r_a_p_ri <= PW'(i_a_re) * PW'(i_b_im);
            r_a_p_bb <= PW'(i_b_re) * PW'(i_b_re);
            r_a_p_cc <= PW'(i_b_im) * PW'(i_b_im);
        end
    end

    // stage b: sums, magnitudes and flags
    cau_pkg::t_ctrl        r_b_ctrl, n_b_ctrl;
    logic signed [VW-1:0]  r_b_val_re, r_b_val_im, n_b_val_re, n_b_val_im;
    logic [PW-1:0]         r_b_num_re, r_b_num_im, r_b_den;
    logic [PW-1:0]         n_b_num_re, n_b_num_im, n_b_den;
    logic signed [VW-1:0]  n_mre, n_mim, n_cre, n_cim, n_are, n_aim, n_bre;
    logic signed [VW-1:0]  n_acre, n_acim;

    always_comb begin
        n_mre  = VW'(r_a_p_rr) - VW'(r_a_p_ii);
        n_mim  = VW'(r_a_p_ir) + VW'(r_a_p_ri);
        n_cre  = VW'(r_a_p_rr) + VW'(r_a_p_ii);
        n_cim  = VW'(r_a_p_ir) - VW'(r_a_p_ri);
        n_acre = n_cre[VW-1] ? -n_cre : n_cre;
        n_acim = n_cim[VW-1] ? -n_cim : n_cim;
        n_are  = r_a_re[W-1]  ? -VW'(r_a_re)  : VW'(r_a_re);
        n_aim  = r_a_im[W-1]  ? -VW'(r_a_im)  : VW'(r_a_im);
        n_bre  = r_a_bre[W-1] ? -VW'(r_a_bre) : VW'(r_a_bre);

        n_b_ctrl      = '0;
        n_b_ctrl.kind = r_a_kind;
        n_b_val_re    = '0;
        n_b_val_im    = '0;
        n_b_num_re    = '0;
        n_b_num_im    = '0;
        n_b_den       = '0;
        case (r_a_kind)
            cau_pkg::KIND_ADD: begin
                n_b_val_re = VW'(r_a_re) + VW'(r_a_bre);
                n_b_val_im = VW'(r_a_im) + VW'(r_a_bim);
            end
            cau_pkg::KIND_SUB: begin
                n_b_val_re = VW'(r_a_re) - VW'(r_a_bre);
                n_b_val_im = VW'(r_a_im) - VW'(r_a_bim);
            end
            cau_pkg::KIND_MUL: begin
                n_b_val_re = n_mre >>> FRAC_BITS;
                n_b_val_im = n_mim >>> FRAC_BITS;
            end
            cau_pkg::KIND_SCALE: begin
                n_b_val_re = VW'(r_a_p_rr) >>> FRAC_BITS;
                n_b_val_im = VW'(r_a_p_ir) >>> FRAC_BITS;
            end
            cau_pkg::KIND_CDIV: begin
                n_b_num_re        = n_acre[PW-1:0];
                n_b_num_im        = n_acim[PW-1:0];
                n_b_den           = $unsigned(r_a_p_bb) + $unsigned(r_a_p_cc);
                n_b_ctrl.neg_re   = n_cre[VW-1];
                n_b_ctrl.neg_im   = n_cim[VW-1];
                n_b_ctrl.div_zero = (r_a_bre == '0) && (r_a_bim == '0);
            end
            cau_pkg::KIND_RDIV: begin
                n_b_num_re        = n_are[PW-1:0];
                n_b_num_im        = n_aim[PW-1:0];
                n_b_den           = n_bre[PW-1:0];
                n_b_ctrl.neg_re   = r_a_re[W-1] ^ r_a_bre[W-1];
                n_b_ctrl.neg_im   = r_a_im[W-1] ^ r_a_bre[W-1];
                n_b_ctrl.div_zero = (r_a_bre == '0);
            end
            cau_pkg::KIND_MAG: begin
                n_b_num_re = $unsigned(r_a_p_rr) + $unsigned(r_a_p_ii);
            end
            default: begin
                n_b_val_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_ctrl   <= n_b_ctrl;
            r_b_val_re <= n_b_val_re;
            r_b_val_im <= n_b_val_im;
            r_b_num_re <= n_b_num_re;
            r_b_num_im <= n_b_num_im;
            r_b_den    <= n_b_den;
        end
    end

    // stage c: scaled dividends and quotient range check
    cau_pkg::t_ctrl        r_c_ctrl, n_c_ctrl;
    logic signed [VW-1:0]  r_c_val_re, r_c_val_im;
    logic [SW-1:0]         r_c_rem_re, r_c_rem_im, n_c_rem_re, n_c_rem_im, n_lim;
    logic [PW-1:0]         r_c_den;
    logic                  n_is_div;

    always_comb begin
        n_is_div   = (r_b_ctrl.kind == cau_pkg::KIND_CDIV) ||
                     (r_b_ctrl.kind == cau_pkg::KIND_RDIV);
        n_c_rem_re = n_is_div ? (SW'(r_b_num_re) << FRAC_BITS) : SW'(r_b_num_re);
        n_c_rem_im = SW'(r_b_num_im) << FRAC_BITS;
        n_lim      = SW'(r_b_den) << W;
        n_c_ctrl        = r_b_ctrl;
        n_c_ctrl.ovf_re = n_is_div && (n_c_rem_re >= n_lim);
        n_c_ctrl.ovf_im = n_is_div && (n_c_rem_im >= n_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_ctrl   <= n_c_ctrl;
            r_c_val_re <= r_b_val_re;
            r_c_val_im <= r_b_val_im;
            r_c_rem_re <= n_c_rem_re;
            r_c_rem_im <= n_c_rem_im;
            r_c_den    <= r_b_den;
        end
    end

    assign o_ctrl   = r_c_ctrl;
    assign o_val_re = r_c_val_re;
    assign o_val_im = r_c_val_im;
    assign o_rem_re = r_c_rem_re;
    assign o_rem_im = r_c_rem_im;
    assign o_den    = r_c_den;

endmodule

[src/cau_step.sv]
// ----------------------------------------------------------------------------
// cau_step
// one quotient or root bit per stage by compare and subtract
// ----------------------------------------------------------------------------
module cau_step #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int BIT_IDX   = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  cau_pkg::t_ctrl                       i_ctrl,
    input  logic signed [2*WORD_BITS:0]          i_val_re,
    input  logic signed [2*WORD_BITS:0]          i_val_im,
    input  logic [3*WORD_BITS+FRAC_BITS-1:0]     i_rem_re,
    input  logic [3*WORD_BITS+FRAC_BITS-1:0]     i_rem_im,
    input  logic [2*WORD_BITS-1:0]               i_den,
    input  logic [WORD_BITS-1:0]                 i_q_re,
    input  logic [WORD_BITS-1:0]                 i_q_im,
    output cau_pkg::t_ctrl                       o_ctrl,
    output logic signed [2*WORD_BITS:0]          o_val_re,
    output logic signed [2*WORD_BITS:0]          o_val_im,
    output logic [3*WORD_BITS+FRAC_BITS-1:0]     o_rem_re,
    output logic [3*WORD_BITS+FRAC_BITS-1:0]     o_rem_im,
    output logic [2*WORD_BITS-1:0]               o_den,
    output logic [WORD_BITS-1:0]                 o_q_re,
    output logic [WORD_BITS-1:0]                 o_q_im
);
    localparam int SW = 3*WORD_BITS+FRAC_BITS;

    logic [SW-1:0]        n_t_re, n_t_im, n_rem_re, n_rem_im;
    logic [WORD_BITS-1:0] n_q_re, n_q_im;
    logic                 n_ge_re, n_ge_im;

    // root trial: 2*root*2^i + 4^i, divider trial: den*2^i
    always_comb begin
        n_t_re = (i_ctrl.kind == cau_pkg::KIND_MAG) ?
                 ((SW'(i_q_re) << (BIT_IDX+1)) | (SW'(1) << (2*BIT_IDX))) :
                 (SW'(i_den) << BIT_IDX);
        n_t_im   = SW'(i_den) << BIT_IDX;
        n_ge_re  = i_rem_re >= n_t_re;
        n_ge_im  = i_rem_im >= n_t_im;
        n_rem_re = n_ge_re ? (i_rem_re - n_t_re) : i_rem_re;
        n_rem_im = n_ge_im ? (i_rem_im - n_t_im) : i_rem_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        n_q_re[BIT_IDX] = n_ge_re;
        n_q_im[BIT_IDX] = n_ge_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctrl   <= i_ctrl;
            o_val_re <= i_val_re;
            o_val_im <= i_val_im;
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_den    <= i_den;
            o_q_re   <= n_q_re;
            o_q_im   <= n_q_im;
        end
    end

endmodule

[src/cau_back.sv]
// ----------------------------------------------------------------------------
// cau_back
// sign, saturation and result selection, one register stage
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  cau_pkg::t_ctrl                i_ctrl,
    input  logic signed [2*WORD_BITS:0]   i_val_re,
    input  logic signed [2*WORD_BITS:0]   i_val_im,
    input  logic [WORD_BITS-1:0]          i_q_re,
    input  logic [WORD_BITS-1:0]          i_q_im,
    output logic signed [WORD_BITS-1:0]   o_re,
    output logic signed [WORD_BITS-1:0]   o_im,
    output logic                          o_div_zero,
    output logic                          o_overflow
);
    localparam int W  = WORD_BITS;
    localparam int VW = 2*WORD_BITS+1;

    localparam logic signed [VW-1:0] VMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0]         WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_val(input logic signed [VW-1:0] v);
        logic [W:0] res;
        if (v > VMAX)      res = {1'b1, WMAX};
        else if (v < VMIN) res = {1'b1, WMIN};
        else               res = {1'b0, v[W-1:0]};
        return res;
    endfunction

    // quotient magnitude to signed word, clamped at the range ends
    function automatic logic [W:0] div_val(input logic [W-1:0] q, input logic neg,
                                           input logic pre_ovf);
        logic [W:0] res;
        if (pre_ovf || (neg ? (q > WMIN) : q[W-1]))
            res = {1'b1, (neg ? WMIN : WMAX)};
        else
            res = {1'b0, (neg ? (-q) : q)};
        return res;
    endfunction

    logic [W:0] n_re, n_im;
    logic       n_dz;

    always_comb begin
        n_re = '0;
        n_im = '0;
        n_dz = 1'b0;
        case (i_ctrl.kind)
            cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_MUL,
            cau_pkg::KIND_SCALE: begin
                n_re = sat_val(i_val_re);
                n_im = sat_val(i_val_im);
            end
            cau_pkg::KIND_CDIV, cau_pkg::KIND_RDIV: begin
                if (i_ctrl.div_zero) begin
                    n_dz = 1'b1;
                end else begin
                    n_re = div_val(i_q_re, i_ctrl.neg_re, i_ctrl.ovf_re);
                    n_im = div_val(i_q_im, i_ctrl.neg_im, i_ctrl.ovf_im);
                end
            end
            cau_pkg::KIND_MAG: begin
                n_re = i_q_re[W-1] ? {1'b1, WMAX} : {1'b0, i_q_re};
            end
            default: begin
                n_dz = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_re       <= n_re[W-1:0];
            o_im       <= n_im[W-1:0];
            o_div_zero <= n_dz;
            o_overflow <= n_re[W] | n_im[W];
        end
    end

endmodule
